// File: sv/nsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, constants and the nucleotide letter decoder for the
// nucleotide segment packer.
// ----------------------------------------------------------------------------
package nsp_pkg;

    localparam int SEGMENT_BASES     = 64;
    localparam int BASES_PER_WORD    = 32;
    localparam int WORDS_PER_SEGMENT = 2;
    localparam int MAX_NODE_LENGTH   = 1048576;

    localparam int CHAR_W   = 8;
    localparam int WORD_W   = 64;
    localparam int LEN_W    = 7;
    localparam int OFFSET_W = 20;
    localparam int POS_W    = $clog2(MAX_NODE_LENGTH + 1);
    localparam int SLOT_W   = 6;

    localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
    localparam logic [POS_W-1:0]    NODE_MAX   = POS_W'(MAX_NODE_LENGTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // presence sets: bit0 A, bit1 C, bit2 G, bit3 T
    localparam logic [3:0] SET_NONE = 4'h0;
    localparam logic [3:0] SET_A    = 4'h1;
    localparam logic [3:0] SET_C    = 4'h2;
    localparam logic [3:0] SET_M    = 4'h3;
    localparam logic [3:0] SET_G    = 4'h4;
    localparam logic [3:0] SET_R    = 4'h5;
    localparam logic [3:0] SET_S    = 4'h6;
    localparam logic [3:0] SET_V    = 4'h7;
    localparam logic [3:0] SET_T    = 4'h8;
    localparam logic [3:0] SET_W    = 4'h9;
    localparam logic [3:0] SET_Y    = 4'hA;
    localparam logic [3:0] SET_H    = 4'hB;
    localparam logic [3:0] SET_K    = 4'hC;
    localparam logic [3:0] SET_D    = 4'hD;
    localparam logic [3:0] SET_B    = 4'hE;
    localparam logic [3:0] SET_N    = 4'hF;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DELTA   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_B = 8'h42;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_D = 8'h44;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_H = 8'h48;
    localparam logic [CHAR_W-1:0] CHAR_K = 8'h4B;
    localparam logic [CHAR_W-1:0] CHAR_M = 8'h4D;
    localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_R = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_S = 8'h53;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_U = 8'h55;
    localparam logic [CHAR_W-1:0] CHAR_V = 8'h56;
    localparam logic [CHAR_W-1:0] CHAR_LETTER_W = 8'h57;
    localparam logic [CHAR_W-1:0] CHAR_Y = 8'h59;

    // one classified base on its way from front to back
    typedef struct packed {
        logic [3:0] base_set;
        logic       cut_after;
        logic       node_last;
    } nsp_op_t;

    function automatic logic [3:0] decode_letter(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] up;
        logic [3:0]        s;
        up = ch;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            up = ch - CASE_DELTA;
        end
        case (up)
            CHAR_A:         s = SET_A;
            CHAR_C:         s = SET_C;
            CHAR_G:         s = SET_G;
            CHAR_T, CHAR_U: s = SET_T;
            CHAR_R:         s = SET_R;
            CHAR_Y:         s = SET_Y;
            CHAR_S:         s = SET_S;
            CHAR_LETTER_W:  s = SET_W;
            CHAR_K:         s = SET_K;
            CHAR_M:         s = SET_M;
            CHAR_B:         s = SET_B;
            CHAR_D:         s = SET_D;
            CHAR_H:         s = SET_H;
            CHAR_V:         s = SET_V;
            CHAR_N:         s = SET_N;
            default:        s = SET_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] set_to_code(input logic [3:0] s);
        logic [1:0] c;
        case (s)
            SET_A:   c = CODE_A;
            SET_C:   c = CODE_C;
            SET_G:   c = CODE_G;
            default: c = CODE_T;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: sv/nsp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsp_front
// Input side: takes one character per beat, classifies it into a presence
// set and hands it with its flags to the queue.
// ----------------------------------------------------------------------------
module nsp_front (
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [nsp_pkg::CHAR_W-1:0]  s_base_char,
    input  wire logic                        s_cut_after,
    input  wire logic                        s_node_last,
    output logic                             push,
    output nsp_pkg::nsp_op_t                 push_op,
    input  wire logic                        q_ready
);
    import nsp_pkg::*;

    assign s_ready = q_ready;
    assign push    = s_valid & q_ready;

    always_comb begin
        push_op.base_set  = decode_letter(s_base_char);
        push_op.cut_after = s_cut_after;
        push_op.node_last = s_node_last;
    end

endmodule
`default_nettype wire

// File: sv/nsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsp_queue
// Short queue of classified bases between the front and back parts.
// ----------------------------------------------------------------------------
module nsp_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire nsp_pkg::nsp_op_t push_op,
    output logic                  q_ready,
    output logic                  q_valid,
    output nsp_pkg::nsp_op_t      head_op,
    input  wire logic             pop
);
    import nsp_pkg::*;

    nsp_op_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign q_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head_op = entry_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

// File: sv/nsp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsp_back
// Segment builder: places each classified base into the packed words and
// presence masks, tracks node position, and loads the output register when
// a segment closes.
// ----------------------------------------------------------------------------
module nsp_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire nsp_pkg::nsp_op_t              head_op,
    output logic                               pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [nsp_pkg::WORD_W-1:0]         m_packed_low,
    output logic [nsp_pkg::WORD_W-1:0]         m_packed_high,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_a,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_c,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_g,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_t,
    output logic [nsp_pkg::LEN_W-1:0]          m_segment_length,
    output logic [nsp_pkg::OFFSET_W-1:0]       m_segment_offset,
    output logic                               m_ambiguous,
    output logic                               m_bad_char,
    output logic                               m_node_end
);
    import nsp_pkg::*;

    // segment state
    logic [WORD_W-1:0] word_reg [WORDS_PER_SEGMENT];
    logic [WORD_W-1:0] word_next [WORDS_PER_SEGMENT];
    logic [WORD_W-1:0] mask_reg [4];
    logic [WORD_W-1:0] mask_next [4];
    logic [LEN_W-1:0]  bases_reg, bases_next;
    logic [POS_W-1:0]  node_pos_reg, node_pos_next;
    logic [POS_W-1:0]  seg_start_reg, seg_start_next;
    logic              amb_reg, amb_next;
    logic              err_reg, err_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] out_word_reg [2];
    logic [WORD_W-1:0] out_mask_reg [4];
    logic [LEN_W-1:0]  out_len_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic              out_amb_reg, out_err_reg, out_end_reg;

    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] slot_bit;
    logic [3:0]        set_eff;
    logic              overflow;
    logic              single;
    logic [LEN_W-1:0]  bases_inc;
    logic              seg_done;
    logic              out_free;
    logic [WORD_W-1:0] code_word;

    assign slot     = bases_reg[SLOT_W-1:0];
    assign slot_bit = WORD_W'(1) << slot;
    assign overflow = (node_pos_reg >= NODE_MAX);
    assign set_eff  = overflow ? SET_NONE : head_op.base_set;
    assign single   = (set_eff == SET_A) || (set_eff == SET_C) ||
                      (set_eff == SET_G) || (set_eff == SET_T);
    assign bases_inc = bases_reg + 1'b1;
    assign seg_done  = (bases_inc >= LEN_W'(SEGMENT_BASES)) ||
                       head_op.cut_after || head_op.node_last;
    assign out_free  = !m_valid_reg || m_ready;
    // a closing beat waits for room in the output register
    assign pop       = q_valid && (!seg_done || out_free);
    assign code_word = WORD_W'(set_to_code(set_eff)) <<
                       {slot[$clog2(BASES_PER_WORD)-1:0], 1'b0};

    always_comb begin
        for (int w = 0; w < WORDS_PER_SEGMENT; w++) begin
            word_next[w] = word_reg[w];
            if (single && (32'(slot) / BASES_PER_WORD == w)) begin
                word_next[w] = word_reg[w] | code_word;
            end
        end
        for (int k = 0; k < 4; k++) begin
            mask_next[k] = set_eff[k] ? (mask_reg[k] | slot_bit) : mask_reg[k];
        end
        seg_start_next = (bases_reg == '0) ? node_pos_reg : seg_start_reg;
        node_pos_next  = overflow ? NODE_MAX : node_pos_reg + 1'b1;
        amb_next       = amb_reg | ((set_eff != SET_NONE) && !single);
        err_next       = err_reg | (set_eff == SET_NONE);
        bases_next     = bases_inc;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop && seg_done) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < WORDS_PER_SEGMENT; w++) begin
                word_reg[w] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                mask_reg[k] <= '0;
            end
            bases_reg     <= '0;
            node_pos_reg  <= '0;
            seg_start_reg <= '0;
            amb_reg       <= 1'b0;
            err_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                seg_start_reg <= seg_start_next;
                if (seg_done) begin
                    for (int w = 0; w < WORDS_PER_SEGMENT; w++) begin
                        word_reg[w] <= '0;
                    end
                    for (int k = 0; k < 4; k++) begin
                        mask_reg[k] <= '0;
                    end
                    bases_reg    <= '0;
                    amb_reg      <= 1'b0;
                    err_reg      <= 1'b0;
                    node_pos_reg <= head_op.node_last ? '0 : node_pos_next;
                end else begin
                    word_reg     <= word_next;
                    mask_reg     <= mask_next;
                    bases_reg    <= bases_next;
                    amb_reg      <= amb_next;
                    err_reg      <= err_next;
                    node_pos_reg <= node_pos_next;
                end
            end
        end
    end

    // result payload, loaded only when the output register has room
    always_ff @(posedge aclk) begin
        if (pop && seg_done) begin
            for (int w = 0; w < 2; w++) begin
                out_word_reg[w] <= (w < WORDS_PER_SEGMENT) ? word_next[w] : '0;
            end
            out_mask_reg   <= mask_next;
            out_len_reg    <= bases_next;
            out_offset_reg <= (seg_start_next > POS_W'(OFFSET_MAX)) ?
                              OFFSET_MAX : seg_start_next[OFFSET_W-1:0];
            out_amb_reg    <= amb_next;
            out_err_reg    <= err_next;
            out_end_reg    <= head_op.node_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_packed_low     = out_word_reg[0];
    assign m_packed_high    = out_word_reg[1];
    assign m_mask_a         = out_mask_reg[0];
    assign m_mask_c         = out_mask_reg[1];
    assign m_mask_g         = out_mask_reg[2];
    assign m_mask_t         = out_mask_reg[3];
    assign m_segment_length = out_len_reg;
    assign m_segment_offset = out_offset_reg;
    assign m_ambiguous      = out_amb_reg;
    assign m_bad_char       = out_err_reg;
    assign m_node_end       = out_end_reg;

endmodule
`default_nettype wire

// File: sv/nucleotide_segment_packer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nucleotide_segment_packer_unit
// Packs a stream of nucleotide characters into 2-bit coded segments with
// per-base presence masks.
// ----------------------------------------------------------------------------
// One character is taken per beat, one beat per cycle while the result side
// keeps up. A character is classified on entry, waits in a two-entry queue,
// and is placed into the open segment by the back part in the cycle it
// leaves the queue; a closing character loads the output register, so a
// segment appears on m_valid once its last character has left the queue.
// Only the output register can hold the stream back: a character that closes
// a segment waits in the queue while the previous segment is still unread,
// and s_ready drops once both queue entries are in use.
module nucleotide_segment_packer_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [nsp_pkg::CHAR_W-1:0]    s_base_char,
    input  wire logic                          s_cut_after,
    input  wire logic                          s_node_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [nsp_pkg::WORD_W-1:0]         m_packed_low,
    output logic [nsp_pkg::WORD_W-1:0]         m_packed_high,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_a,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_c,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_g,
    output logic [nsp_pkg::WORD_W-1:0]         m_mask_t,
    output logic [nsp_pkg::LEN_W-1:0]          m_segment_length,
    output logic [nsp_pkg::OFFSET_W-1:0]       m_segment_offset,
    output logic                               m_ambiguous,
    output logic                               m_bad_char,
    output logic                               m_node_end
);
    import nsp_pkg::*;

    logic    push;
    nsp_op_t push_op;
    logic    q_ready;
    logic    q_valid;
    nsp_op_t head_op;
    logic    pop;

    nsp_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base_char (s_base_char),
        .s_cut_after (s_cut_after),
        .s_node_last (s_node_last),
        .push        (push),
        .push_op     (push_op),
        .q_ready     (q_ready)
    );

    nsp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready),
        .q_valid (q_valid),
        .head_op (head_op),
        .pop     (pop)
    );

    nsp_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .head_op          (head_op),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packed_low     (m_packed_low),
        .m_packed_high    (m_packed_high),
        .m_mask_a         (m_mask_a),
        .m_mask_c         (m_mask_c),
        .m_mask_g         (m_mask_g),
        .m_mask_t         (m_mask_t),
        .m_segment_length (m_segment_length),
        .m_segment_offset (m_segment_offset),
        .m_ambiguous      (m_ambiguous),
        .m_bad_char       (m_bad_char),
        .m_node_end       (m_node_end)
    );

endmodule
`default_nettype wire

// File: sv/nsp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nsp_checker
// Port-level checks on the segment packer's result channel.
// ----------------------------------------------------------------------------
module nsp_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [nsp_pkg::WORD_W-1:0]    m_packed_low,
    input wire logic [nsp_pkg::WORD_W-1:0]    m_mask_a,
    input wire logic [nsp_pkg::WORD_W-1:0]    m_mask_c,
    input wire logic [nsp_pkg::WORD_W-1:0]    m_mask_g,
    input wire logic [nsp_pkg::WORD_W-1:0]    m_mask_t,
    input wire logic [nsp_pkg::LEN_W-1:0]     m_segment_length,
    input wire logic                          m_ambiguous
);
    import nsp_pkg::*;

    logic [WORD_W-1:0] any_mask;
    logic [WORD_W-1:0] multi_mask;

    assign any_mask   = m_mask_a | m_mask_c | m_mask_g | m_mask_t;
    assign multi_mask = (m_mask_a & m_mask_c) | (m_mask_a & m_mask_g) |
                        (m_mask_a & m_mask_t) | (m_mask_c & m_mask_g) |
                        (m_mask_c & m_mask_t) | (m_mask_g & m_mask_t);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled beat keeps its low packed word and its segment length
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packed_low) &&
                                $stable(m_segment_length))
        else $error("stalled result changed");

    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_segment_length != '0) &&
                    (m_segment_length <= LEN_W'(SEGMENT_BASES)))
        else $error("segment length out of range");

    // no presence bit beyond the segment's last base
    a_mask_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((any_mask >> m_segment_length) == '0))
        else $error("mask bit beyond segment length");

    // a segment with several candidates at one position must be flagged
    a_ambiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ambiguous |-> (multi_mask == '0))
        else $error("ambiguous position without ambiguous flag");

endmodule

bind nucleotide_segment_packer_unit nsp_checker u_nsp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_packed_low     (m_packed_low),
    .m_mask_a         (m_mask_a),
    .m_mask_c         (m_mask_c),
    .m_mask_g         (m_mask_g),
    .m_mask_t         (m_mask_t),
    .m_segment_length (m_segment_length),
    .m_ambiguous      (m_ambiguous)
);
`default_nettype wire
